[rtl/core/lg2p_pkg.sv]
// ----------------------------------------------------------------------------
// lg2p_pkg
// Shared types and constants of the polynomial log2 approximation core.
// ----------------------------------------------------------------------------
package lg2p_pkg;

  localparam int MANT_FRAC = 23;
  localparam int COEF_FRAC = 28;
  localparam int EXP_W     = 8;
  localparam int M_W       = MANT_FRAC + 1;
  localparam int P_W       = 32;
  localparam int OUT_W     = 25;
  localparam int NUM_COEF  = 6;

  localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;
  localparam logic [EXP_W-1:0] EXP_ALL1 = 8'hFF;

  typedef logic signed [P_W-1:0]   p_t;
  typedef logic        [M_W-1:0]   mant_t;
  typedef logic        [EXP_W-1:0] exp_t;
  typedef logic signed [OUT_W-1:0] out_t;

  // horner coefficients, 28 fraction bits, c0 first
  localparam p_t COEF [NUM_COEF] = '{
    32'sd836388483,
    -32'sd892332874,
    32'sd697622196,
    -32'sd330586398,
    32'sd85419751,
    -32'sd9243845
  };

  localparam out_t OUT_MAX = 25'sh0FFFFFF;
  localparam out_t OUT_MIN = 25'sh1000000;

  // operand set carried beside the polynomial
  typedef struct packed {
    mant_t m;
    exp_t  expf;
    logic  neg;
  } item_t;

endpackage

[rtl/core/lg2p_horner_step.sv]
// ----------------------------------------------------------------------------
// lg2p_horner_step
// One registered horner step: p_out = floor(p_in * m / 2^23) + coef.
// ----------------------------------------------------------------------------
module lg2p_horner_step
  import lg2p_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  p_t    p_in,
  input  mant_t m_in,
  input  p_t    coef,
  output p_t    p_out
);

  logic signed [P_W+M_W:0]       prod;
  logic signed [P_W+M_W-MANT_FRAC:0] sh;
  logic signed [P_W+M_W-MANT_FRAC:0] sum;

  always_comb begin
    prod = p_in * $signed({1'b0, m_in});
    // floor shift: drop the low mantissa bits of the signed product
    sh   = $signed(prod[P_W+M_W:MANT_FRAC]);
    sum  = sh + (P_W+M_W-MANT_FRAC+1)'(coef);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out <= sum[P_W-1:0];
    end
  end

endmodule

[rtl/core/log2_polynomial_approx_core.sv]
// ----------------------------------------------------------------------------
// log2_polynomial_approx_core
// Approximate log2 of a single-precision value, Q9.16 fixed-point result.
// ----------------------------------------------------------------------------
// Eight-stage pipeline taking one transaction per clock while out_stall is
// low: decode, five horner multiply-add stages (one 32x25 multiply each),
// the fraction multiply, then the integer add with saturation. An accepted
// input moves through these stages in order to its result on out_valid. A stall on
// the output only holds stages that are full, so bubbles are squeezed out.
// Zero, negative and NaN inputs give neg_inf with the most negative code.
module log2_polynomial_approx_core
  import lg2p_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 16
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] float_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        log2_value,
  output logic        neg_inf
);

  localparam int NST  = 8;
  localparam int NH   = NUM_COEF - 1;
  localparam int FSH  = COEF_FRAC + MANT_FRAC - OUT_FRAC_BITS;
  localparam int PR_W = P_W + M_W;
  localparam int FW   = PR_W - FSH;
  // wide enough for the unsaturated sum and for the saturation bounds
  localparam int SW   = (OUT_FRAC_BITS + 11 > OUT_W + 1) ? OUT_FRAC_BITS + 11 : OUT_W + 1;

  localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

  logic [NST:1]   vld;
  logic [NST+1:1] rdy;

  item_t it_s [1:NH+1];
  p_t    p_chain [0:NH];

  // stage 7 and 8 registers
  exp_t                 expf7;
  logic                 neg7;
  logic signed [FW-1:0] fpart7;
  out_t                 log2_value_r;
  logic                 neg_r;

  // decode
  logic  [EXP_W-1:0] in_exp;
  logic              in_nan;
  item_t             in_item;

  always_comb begin
    in_exp       = float_bits[30:23];
    in_nan       = (in_exp == EXP_ALL1) && (float_bits[22:0] != '0);
    in_item.m    = {1'b1, float_bits[22:0]};
    in_item.expf = in_exp;
    in_item.neg  = float_bits[31] || (float_bits == '0) || in_nan;
  end

  // ready chain: a stage loads when empty or when its contents move on
  always_comb begin
    rdy[NST+1] = !out_stall;
    for (int i = NST; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // operand pipeline alongside the horner stages
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      it_s[1] <= in_item;
    end
    for (int i = 2; i <= NH + 1; i++) begin
      if (rdy[i]) begin
        it_s[i] <= it_s[i-1];
      end
    end
  end

  assign p_chain[0] = COEF[NUM_COEF-1];

  for (genvar j = 0; j < NH; j++) begin : g_horner
    lg2p_horner_step u_step (
      .clk   (clk),
      .en    (rdy[j+2]),
      .p_in  (p_chain[j]),
      .m_in  (it_s[j+1].m),
      .coef  (COEF[NH-1-j]),
      .p_out (p_chain[j+1])
    );
  end

  // fraction term: floor(p * (m - 1) / 2^FSH)
  logic signed [PR_W-1:0] prod2;
  logic signed [PR_W-1:0] prod2_sh;

  always_comb begin
    prod2    = p_chain[NH] * $signed({1'b0, it_s[NH+1].m[MANT_FRAC-1:0]});
    prod2_sh = prod2 >>> FSH;
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      expf7  <= it_s[NH+1].expf;
      neg7   <= it_s[NH+1].neg;
      fpart7 <= prod2_sh[FW-1:0];
    end
  end

  // integer part plus fraction, saturated
  logic signed [EXP_W+1:0] e_sgn;
  logic signed [SW-1:0]    val;
  out_t                    val_sat;

  always_comb begin
    e_sgn = $signed({2'b00, expf7}) - $signed({2'b00, EXP_BIAS});
    val   = (SW'(e_sgn) <<< OUT_FRAC_BITS) + SW'(fpart7);
    if (neg7) begin
      val_sat = OUT_MIN;
    end else if (val > SAT_HI) begin
      val_sat = OUT_MAX;
    end else if (val < SAT_LO) begin
      val_sat = OUT_MIN;
    end else begin
      val_sat = val[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      log2_value_r <= val_sat;
      neg_r        <= neg7;
    end
  end

  assign out_valid  = vld[NST];
  assign log2_value = log2_value_r;
  assign neg_inf    = neg_r;

endmodule

[rtl/core/lg2p_checker.sv]
// ----------------------------------------------------------------------------
// lg2p_checker
// Port-level checks of the log2 core, bound to the top level.
// ----------------------------------------------------------------------------
module lg2p_checker
  import lg2p_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] float_bits,
  input logic        out_valid,
  input logic        out_stall,
  input out_t        log2_value,
  input logic        neg_inf
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(log2_value) && $stable(neg_inf))
    else $error("stalled result changed");

  // with the output free the pipeline never backs up
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  // minus infinity always carries the most negative code
  a_neg_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && neg_inf |-> log2_value == OUT_MIN)
    else $error("neg_inf with wrong code");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(float_bits))
    else $error("stalled input changed");

endmodule

bind log2_polynomial_approx_core lg2p_checker u_lg2p_checker (.*);

[bench/tb_log2_polynomial_approx_core.sv]
// ----------------------------------------------------------------------------
// tb_log2_polynomial_approx_core
// Streams single-precision bit patterns through the log2 core under random
// input gaps and output stalls. Each result is checked field by field against
// a bit-exact fixed-point model of the horner evaluation kept in this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_log2_polynomial_approx_core;
  import lg2p_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int RANDOM_FLOATS = 1000;

  typedef struct packed {
    out_t value;
    logic neg_inf;
  } log2_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] float_bits;
  logic        out_valid;
  logic        out_stall;
  out_t        log2_value;
  logic        neg_inf;

  log2_result_t pending_logs[$];
  log2_result_t oldest_log;
  int           mismatches = 0;
  bit           gaps_on = 1;

  log2_polynomial_approx_core #(
    .OUT_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .float_bits(float_bits),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .log2_value(log2_value),
    .neg_inf   (neg_inf)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // fixed-point log2: horner in 28 fraction bits, floor on every shift
  function automatic log2_result_t approx_log2(logic [31:0] bits);
    exp_t         e;
    logic [22:0]  frac;
    longint       m;
    longint       p;
    longint       fpart;
    longint       v;
    log2_result_t r;
    e = bits[30:23];
    frac = bits[22:0];
    if (bits[31] || bits == 32'd0 || (e == EXP_ALL1 && frac != 23'd0)) begin
      r.value = OUT_MIN;
      r.neg_inf = 1'b1;
      return r;
    end
    m = longint'({1'b1, frac});
    p = longint'(COEF[NUM_COEF-1]);
    for (int k = NUM_COEF - 2; k >= 0; k--) begin
      p = ((p * m) >>> MANT_FRAC) + longint'(COEF[k]);
    end
    fpart = (p * (m - (64'sd1 << MANT_FRAC))) >>> (COEF_FRAC + MANT_FRAC - FRAC_BITS);
    v = (longint'(e) - longint'(EXP_BIAS)) * (64'sd1 << FRAC_BITS) + fpart;
    if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
    if (v < longint'(OUT_MIN)) v = longint'(OUT_MIN);
    r.value = out_t'(v);
    r.neg_inf = 1'b0;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic send_float(logic [31:0] bits);
    int n;
    @(negedge clk);
    in_valid <= 1'b1;
    float_bits <= bits;
    do @(posedge clk); while (in_stall);
    pending_logs.push_back(approx_log2(bits));
    n = gaps_on ? idle_len() : 0;
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      float_bits <= $urandom();
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // zeros, negatives, nans and infinities
  task automatic test_special_values();
    send_float(32'h0000_0000);
    send_float(32'h8000_0000);
    send_float(32'hBF80_0000);
    send_float(32'h8000_0001);
    send_float(32'hFF80_0000);
    send_float(32'h7FC0_0000);
    send_float(32'h7F80_0001);
    send_float(32'h7FFF_FFFF);
    send_float(32'hFFFF_FFFF);
    send_float(32'h7F80_0000);
  endtask

  // denormals, exponent and mantissa extremes
  task automatic test_boundaries();
    send_float(32'h0000_0001);
    send_float(32'h0040_0000);
    send_float(32'h007F_FFFF);
    send_float(32'h0080_0000);
    send_float(32'h3F80_0000);
    send_float(32'h3F80_0001);
    send_float(32'h3FC0_0000);
    send_float(32'h3FFF_FFFF);
    send_float(32'h4000_0000);
    send_float(32'h7F00_0000);
    send_float(32'h7F7F_FFFF);
  endtask

  task automatic test_random_floats();
    int          r;
    logic [22:0] frac;
    for (int i = 0; i < RANDOM_FLOATS; i++) begin
      // every third block of 100 runs back to back
      gaps_on = ((i / 100) % 3) != 0;
      r = $urandom_range(99);
      frac = 23'($urandom());
      if (r < 5) frac = '0;
      else if (r < 10) frac = '1;
      if (r < 75) send_float({1'b0, exp_t'($urandom_range(0, 254)), frac});
      else send_float($urandom());
    end
    gaps_on = 1;
  endtask

  // output stall: free-running stretches, short and long holds
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      n = ($urandom_range(3) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 6);
      @(negedge clk);
      out_stall <= 1'b0;
      repeat (n - 1) @(negedge clk);
      n = idle_len();
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_logs.size() == 0) begin
        report_mismatch("transaction with nothing pending", 0, log2_value);
      end else begin
        oldest_log = pending_logs.pop_front();
        if (log2_value !== oldest_log.value)
          report_mismatch("log2_value", oldest_log.value, log2_value);
        if (neg_inf !== oldest_log.neg_inf)
          report_mismatch("neg_inf", oldest_log.neg_inf, neg_inf);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    float_bits = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_values();
    test_boundaries();
    test_random_floats();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_logs.size() != 0) @(posedge clk);
    // catch anything extra coming out of the pipeline
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
